// ----- hdl/u2a_pkg.sv -----
// ----------------------------------------------------------------------------
// u2a_pkg - shared constants for the unsigned-to-ASCII digit converter
// Field widths, ASCII offset and radix limits used by the RTL and checker.
// ----------------------------------------------------------------------------
package u2a_pkg;

	// payload field widths
	localparam int DIGIT_W = 4;   // one stored remainder
	localparam int CHAR_W  = 6;   // digit_char
	localparam int COUNT_W = 6;   // digit_count
	localparam int RADIX_W = 4;   // radix register

	// output tdata is digit_char then digit_count, padded to two bytes
	localparam int M_DATA_W = 16;

	// dividend bits consumed per cycle by the shared divide slice
	localparam int STEP_BITS = 8;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 6'd48;
	localparam logic [CHAR_W-1:0]  ASCII_NINE    = 6'd57;
	localparam logic [RADIX_W-1:0] RADIX_MIN     = 4'd2;
	localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 4'd10;

endpackage

// ----- hdl/unsigned_to_ascii_digits_top.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_top - unsigned integer to ASCII digits
// Divides each value by the configured radix one digit at a time with a
// shared compare/subtract slice, stores the remainders and streams them
// out most significant digit first.
// ----------------------------------------------------------------------------
// Sequence: accept a value, then run the divide slice over the whole dividend
//   once per digit, then send each digit by a read state followed by a show state.
// Throughput: one value at a time; s_tready is high only between runs.
// The divide slice retires 8 dividend bits per cycle; each beat is preceded by a
//   registered read of the digit store.
// Reset: control state cleared, radix set to 10; digit store is not cleared.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits_top
	import u2a_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  logic clk,
	input  logic arst_n,

	// configuration: radix
	input  logic                cfg_we,
	input  logic [RADIX_W-1:0]  cfg_wdata,

	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,  // value, zero pad

	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,  // digit_char[5:0], digit_count[11:6], zero pad
	output logic                  m_tlast   // last_digit
);

	localparam int DATA_W = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int NSTEP  = DATA_W / STEP_BITS;
	localparam int SW     = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int IW     = $clog2(MAX_DIGITS);
	localparam int CW     = $clog2(MAX_DIGITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_SHOW = 2'd3;

	logic [1:0]         state_q;
	logic [RADIX_W-1:0] radix_q;
	logic [DATA_W-1:0]  quot_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [SW-1:0]      step_q;
	logic [CW-1:0]      cnt_q;
	logic [IW-1:0]      rd_idx_q;
	logic [DIGIT_W-1:0] rd_data_q;

	logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

	logic [RADIX_W-1:0] base;
	logic [DATA_W-1:0]  new_quot;
	logic [DIGIT_W-1:0] new_rem;
	logic               last_step;
	logic               digit_done;
	logic               run_end;
	logic [CHAR_W-1:0]  char_code;

	// clamp the radix register to 2..10
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > DEFAULT_RADIX) begin
			base = DEFAULT_RADIX;
		end else begin
			base = radix_q;
		end
	end

	// shared divide slice: STEP_BITS restoring steps on a narrow remainder
	always_comb begin
		logic [DIGIT_W:0]      r;
		logic [STEP_BITS-1:0]  qbits;
		logic [STEP_BITS-1:0]  top;
		r     = {1'b0, rem_q};
		qbits = '0;
		top   = quot_q[DATA_W-1 -: STEP_BITS];
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {r[DIGIT_W-1:0], top[STEP_BITS-1-i]};
			if (r >= {1'b0, base}) begin
				r = r - {1'b0, base};
				qbits[STEP_BITS-1-i] = 1'b1;
			end
		end
		new_rem  = r[DIGIT_W-1:0];
		new_quot = (quot_q << STEP_BITS) | DATA_W'(qbits);
	end

	assign last_step  = (step_q == SW'(NSTEP - 1));
	assign digit_done = (state_q == ST_DIV) && last_step;
	assign run_end    = (new_quot == '0) || (cnt_q + CW'(1) == CW'(MAX_DIGITS));

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= DEFAULT_RADIX;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						step_q <= '0;
						cnt_q  <= cnt_q + CW'(1);
						if (run_end) begin
							rd_idx_q <= cnt_q[IW-1:0];
							state_q  <= ST_RD;
						end
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_RD: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (m_tready) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - IW'(1);
							state_q  <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// dividend / quotient and partial remainder
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			quot_q <= DATA_W'(s_tdata[VALUE_BITS-1:0]);
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			quot_q <= new_quot;
			rem_q  <= last_step ? '0 : new_rem;
		end
	end

	// digit store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_mem[cnt_q[IW-1:0]] <= new_rem;
		end
		if (state_q == ST_RD) begin
			rd_data_q <= digit_mem[rd_idx_q];
		end
	end

	// stream ports
	assign char_code = ASCII_ZERO + CHAR_W'(rd_data_q);
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_SHOW);
	assign m_tdata   = M_DATA_W'({COUNT_W'(cnt_q), char_code});
	assign m_tlast   = (rd_idx_q == '0);

endmodule

// ----- hdl/u2a_checker.sv -----
// ----------------------------------------------------------------------------
// u2a_checker - port-level checks for the digit converter
// Watches the stream ports of the top level over time; bound in below.
// ----------------------------------------------------------------------------
module u2a_checker
	import u2a_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	// no new value is taken while digits are being sent
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output beat pending");

	// mid-run beat: the run goes on, no input accepted next cycle
	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> !s_tready)
		else $error("input accepted in the middle of a digit run");

	// digit count field holds after every mid-run beat
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tdata[CHAR_W +: COUNT_W] == $past(m_tdata[CHAR_W +: COUNT_W])))
		else $error("digit count changed within a run");

	// every beat carries an ASCII decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CHAR_W-1:0] >= ASCII_ZERO &&
			m_tdata[CHAR_W-1:0] <= ASCII_NINE))
		else $error("digit character out of range");

	// stalled beat holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
			$stable(m_tlast)))
		else $error("stalled output beat changed");

endmodule

bind unsigned_to_ascii_digits_top u2a_checker u_u2a_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for unsigned_to_ascii_digits_top
// Streams 32-bit values through the converter under every radix from 2 to 10,
// including out-of-range register values, with random gaps on both sides and
// one long output stall. Each digit beat is checked against a local
// divide-by-radix model that tracks the radix register.
// ----------------------------------------------------------------------------
module testbench
	import u2a_pkg::*;
();

	localparam int VALUE_W       = 32;
	localparam int MAX_DIGITS    = 32;
	localparam int RANDOM_PER_SET = 26;
	localparam int PRESSURE_AT   = 50;    // values accepted before the long stall
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 200;
	localparam int WATCHDOG_MAX  = 3000;

	typedef struct packed {
		logic [CHAR_W-1:0]  digit_char;
		logic               last_digit;
		logic [COUNT_W-1:0] digit_count;
	} digit_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                cfg_we = 1'b0;
	logic [RADIX_W-1:0]  cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [VALUE_W-1:0]  s_tdata = '0;   // value
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;       // digit_char, digit_count, zero pad
	logic                m_tlast;       // last_digit

	// stimulus and scoreboard state
	logic [VALUE_W-1:0] pending_values[$];
	digit_beat_t        expected_digits[$];
	logic [RADIX_W-1:0] radix_reg = DEFAULT_RADIX;
	int                 values_queued = 0;
	int                 values_sent = 0;
	int                 idle_max = 6;
	int                 gap_left = 0;
	int                 ready_wait = 0;
	int                 hold_left = 0;
	bit                 hold_done = 1'b0;
	int                 quiet_cycles = 0;
	int                 mismatches = 0;

	unsigned_to_ascii_digits_top #(
		.VALUE_BITS(VALUE_W),
		.MAX_DIGITS(MAX_DIGITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// radix register as the block sees it: below 2 acts as 2, above 10 as 10
	function automatic logic [RADIX_W-1:0] effective_radix();
		if (radix_reg < RADIX_MIN)
			return RADIX_MIN;
		if (radix_reg > DEFAULT_RADIX)
			return DEFAULT_RADIX;
		return radix_reg;
	endfunction

	// split a value into digits and queue them, most significant first
	function automatic void queue_digits(logic [VALUE_W-1:0] value);
		logic [DIGIT_W-1:0] rems[MAX_DIGITS];
		logic [VALUE_W-1:0] quot;
		logic [RADIX_W-1:0] base;
		digit_beat_t        beat;
		int                 n;
		base = effective_radix();
		quot = value;
		n = 0;
		do begin
			rems[n] = DIGIT_W'(quot % base);
			quot = quot / base;
			n++;
		end while (quot != 0 && n < MAX_DIGITS);
		for (int k = n - 1; k >= 0; k--) begin
			beat.digit_char  = ASCII_ZERO + CHAR_W'(rems[k]);
			beat.last_digit  = (k == 0);
			beat.digit_count = COUNT_W'(n);
			expected_digits.push_back(beat);
		end
	endfunction

	// random value: full range, random length, small, or near a power of the radix
	function automatic logic [VALUE_W-1:0] draw_value();
		logic [63:0] pow;
		int          k;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(0, 31);
			2: return $urandom_range(0, 200);
			default: begin
				pow = 1;
				k = $urandom_range(0, 31);
				repeat (k)
					if (pow * effective_radix() <= 64'hFFFF_FFFF)
						pow = pow * effective_radix();
				return VALUE_W'(pow) - VALUE_W'($urandom_range(0, 1));
			end
		endcase
	endfunction

	task automatic send_value(logic [VALUE_W-1:0] value);
		pending_values.push_back(value);
		values_queued++;
	endtask

	// wait until every value is in and every digit is out, then let it settle
	task automatic wait_drained();
		while (!(values_sent == values_queued && expected_digits.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(logic [RADIX_W-1:0] radix);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= radix;
		@(posedge clk);
		cfg_we    <= 1'b0;
		radix_reg = radix;
	endtask

	// input driver: random gap after each beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				queue_digits(s_tdata);
				values_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_values.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_values.pop_front();
					gap_left <= $urandom_range(0, idle_max);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// one long output stall once traffic is under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && values_sent >= PRESSURE_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output monitor: check each digit beat, random stall after each one
	always @(posedge clk or negedge arst_n) begin : digit_monitor
		int          stall;
		digit_beat_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_wait <= 0;
		end else begin
			stall = ready_wait;
			if (m_tvalid && m_tready) begin
				stall = $urandom_range(0, idle_max);
				if (expected_digits.size() == 0) begin
					$error("digit beat with nothing expected: tdata=%0d", m_tdata);
					mismatches++;
				end else begin
					want = expected_digits.pop_front();
					if (m_tdata[CHAR_W-1:0] !== want.digit_char) begin
						$error("digit_char: expected %0d, got %0d",
							want.digit_char, m_tdata[CHAR_W-1:0]);
						mismatches++;
					end
					if (m_tlast !== want.last_digit) begin
						$error("last_digit: expected %0d, got %0d", want.last_digit, m_tlast);
						mismatches++;
					end
					if (m_tdata[CHAR_W +: COUNT_W] !== want.digit_count) begin
						$error("digit_count: expected %0d, got %0d",
							want.digit_count, m_tdata[CHAR_W +: COUNT_W]);
						mismatches++;
					end
				end
			end
			if (stall != 0) begin
				m_tready   <= 1'b0;
				ready_wait <= stall - 1;
			end else begin
				m_tready   <= (hold_left == 0);
				ready_wait <= 0;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		int radix_plan[$];
		radix_plan = '{2, 0, 1, 3, 4, 5, 6, 7, 8, 9, 11, 15, 10};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset radix: decimal corners and alternating bit patterns
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd9);
		send_value(32'd10);
		send_value(32'd99);
		send_value(32'd100);
		send_value(32'd1_000_000_000);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h5555_5555);
		send_value(32'hAAAA_AAAA);
		repeat (RANDOM_PER_SET) send_value(draw_value());
		wait_drained();

		foreach (radix_plan[i]) begin
			write_radix(RADIX_W'(radix_plan[i]));
			// every fourth setting runs with no idling on either side
			idle_max = (i % 4 == 1) ? 0 : 6;
			if (radix_plan[i] == 2 || radix_plan[i] == 15) begin
				send_value(32'd0);
				send_value(32'd1);
				send_value(32'hFFFF_FFFF);
				if (radix_plan[i] == 2)
					send_value(32'h8000_0000);
			end
			repeat (RANDOM_PER_SET) send_value(draw_value());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_digits.size() != 0) begin
			$error("%0d expected digits never arrived", expected_digits.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
